/* sv/mtes_pkg.sv */
// shared constants for the multi timer expiry scheduler
// timer table sizing, time width, field widths, request function codes and result kind codes; no dependencies
package mtes_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int TIME_BITS  = 32;

  // table index and entry count widths
  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);

  // fixed field widths
  localparam int DELAY_W    = 31;
  localparam int TAG_W      = 8;
  localparam int KIND_W     = 2;
  localparam int OUT_TIME_W = 32;

  // sign bit of a time difference
  localparam logic [TIME_BITS-1:0] TIME_TOP = {1'b1, {(TIME_BITS-1){1'b0}}};

  // request function codes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

endpackage

/* sv/multi_timer_expiry_scheduler.sv */
// channel   handshake             payload
// request   req_valid/req_stall   func, delay_ms, period_ms, handler_tag
// result    rsp_valid/rsp_stall   kind, fired_tag, fire_time, last
//
// a set transaction is accepted in idle, then its answer waits in flush for the result register
// a tick is accepted in idle, then makes one scan per fire plus a final scan, each
// walking the entries at the count of that scan, one entry per cycle through a
// single subtract and compare unit, then the flush state hands over the last fire
// reset clears time, entry count and control; table contents need no reset
// a stalled result holds; the sequencer waits on it only with another result ready
// depends on mtes_pkg
module multi_timer_expiry_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          func,
  input  logic [mtes_pkg::DELAY_W-1:0]  delay_ms,
  input  logic [mtes_pkg::DELAY_W-1:0]  period_ms,
  input  logic [mtes_pkg::TAG_W-1:0]    handler_tag,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [mtes_pkg::KIND_W-1:0]   kind,
  output logic [mtes_pkg::TAG_W-1:0]    fired_tag,
  output logic [mtes_pkg::OUT_TIME_W-1:0] fire_time,
  output logic                          last
);
  import mtes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH
  } state_t;

  state_t state;

  // timer table
  logic [TIME_BITS-1:0] expiry_time   [MAX_TIMERS];
  logic [DELAY_W-1:0]   reload_period [MAX_TIMERS];
  logic [TAG_W-1:0]     entry_tag     [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] done;

  logic [TIME_BITS-1:0] now_ms;
  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     idx;

  // best candidate of the current scan
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_key;
  logic [TIME_BITS-1:0] best_exp;
  logic [DELAY_W-1:0]   best_per;
  logic [TAG_W-1:0]     best_tag;

  // result waiting for the next scan to tell whether it is the last one
  logic                 pend_valid;
  logic [KIND_W-1:0]    pend_kind;
  logic [TAG_W-1:0]     pend_tag;

  logic [IDX_W-1:0]     rd_idx;
  logic [TIME_BITS-1:0] rd_exp;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] key;
  logic                 due;
  logic                 cand;
  logic                 slot_free;
  logic                 room;
  logic                 set_wr;
  logic                 commit_go;
  logic                 rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign room      = (entry_count < CNT_W'(MAX_TIMERS));

  // shared compare unit: one entry per scan cycle
  always_comb begin
    rd_idx = idx[IDX_W-1:0];
    rd_exp = expiry_time[rd_idx];
    diff   = rd_exp - now_ms;
    key    = diff ^ TIME_TOP;
    due    = (diff == '0) || diff[TIME_BITS-1];
    cand   = !done[rd_idx] && due && (!found || (key < best_key));
  end

  // table write strobes and result register load
  always_comb begin
    set_wr    = (state == ST_IDLE) && req_valid && (func == FUNC_SET) && room;
    commit_go = (state == ST_COMMIT) && found && (slot_free || !pend_valid);
    rsp_load  = (commit_go && pend_valid) || ((state == ST_FLUSH) && slot_free);
  end

  // table storage: append on set, reload or remove on fire
  always_ff @(posedge clk) begin
    if (set_wr) begin
      expiry_time[entry_count[IDX_W-1:0]]   <= now_ms + TIME_BITS'(delay_ms);
      reload_period[entry_count[IDX_W-1:0]] <= period_ms;
      entry_tag[entry_count[IDX_W-1:0]]     <= handler_tag;
    end else if (commit_go) begin
      if (best_per != '0) begin
        expiry_time[best_idx] <= best_exp + TIME_BITS'(best_per);
      end else begin
        for (int i = 0; i < MAX_TIMERS - 1; i++) begin
          if (i >= int'(best_idx)) begin
            expiry_time[i]   <= expiry_time[i+1];
            reload_period[i] <= reload_period[i+1];
            entry_tag[i]     <= entry_tag[i+1];
          end
        end
      end
    end
  end

  // sequencer, scan registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      now_ms      <= '0;
      entry_count <= '0;
      idx         <= '0;
      found       <= 1'b0;
      done        <= '0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // result valid: load a new result or release an accepted one
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (func == FUNC_SET) begin
              pend_kind  <= room ? KIND_ACCEPT : KIND_FULL;
              pend_tag   <= handler_tag;
              pend_valid <= 1'b1;
              if (room) begin
                entry_count <= entry_count + 1'b1;
              end
              state <= ST_FLUSH;
            end else begin
              now_ms <= now_ms + 1'b1;
              done   <= '0;
              idx    <= '0;
              found  <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx == entry_count) begin
            state <= ST_COMMIT;
          end else begin
            if (cand) begin
              found    <= 1'b1;
              best_idx <= rd_idx;
              best_key <= key;
              best_exp <= rd_exp;
              best_per <= reload_period[rd_idx];
              best_tag <= entry_tag[rd_idx];
            end
            idx <= idx + 1'b1;
          end
        end
        ST_COMMIT: begin
          if (!found) begin
            state <= pend_valid ? ST_FLUSH : ST_IDLE;
          end else if (slot_free || !pend_valid) begin
            // hand over the previous fire, it was not the last one
            if (pend_valid) begin
              kind      <= pend_kind;
              fired_tag <= pend_tag;
              fire_time <= OUT_TIME_W'(now_ms);
              last      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_kind  <= KIND_FIRE;
            pend_tag   <= best_tag;
            if (best_per != '0) begin
              done[best_idx] <= 1'b1;
            end else begin
              for (int i = 0; i < MAX_TIMERS; i++) begin
                if (i >= int'(best_idx)) begin
                  done[i] <= (i < MAX_TIMERS - 1) ? done[(i+1) % MAX_TIMERS] : 1'b0;
                end
              end
              entry_count <= entry_count - 1'b1;
            end
            idx   <= '0;
            found <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            kind       <= pend_kind;
            fired_tag  <= pend_tag;
            fire_time  <= OUT_TIME_W'(now_ms);
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/mtes_checker.sv */
// port level checks for the multi timer expiry scheduler
// bound to multi_timer_expiry_scheduler; depends on mtes_pkg
module mtes_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            func,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [mtes_pkg::KIND_W-1:0]     kind,
  input logic [mtes_pkg::TAG_W-1:0]      fired_tag,
  input logic [mtes_pkg::OUT_TIME_W-1:0] fire_time,
  input logic                            last
);
  import mtes_pkg::*;

  // a stalled result transaction holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(fired_tag)
      && $stable(fire_time) && $stable(last))
    else $error("result changed while stalled");

  // the block is busy right after taking a set transaction
  a_set_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (func == FUNC_SET) |=> req_stall)
    else $error("request taken while a set is in progress");

  // only defined kinds are produced
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (kind == KIND_ACCEPT) || (kind == KIND_FULL) || (kind == KIND_FIRE))
    else $error("undefined result kind");

  // a set answer is always the only result of its transaction
  a_set_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind != KIND_FIRE) |-> last)
    else $error("set answer without last");

endmodule

bind multi_timer_expiry_scheduler mtes_checker u_mtes_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .func      (func),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .kind      (kind),
  .fired_tag (fired_tag),
  .fire_time (fire_time),
  .last      (last)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the multi timer expiry scheduler
// directed table then random set and tick transactions, checked by a timer table predictor
// depends on mtes_pkg and multi_timer_expiry_scheduler
module testbench;
  import mtes_pkg::*;

  localparam int N_DIRECTED   = 27;
  localparam int N_RANDOM     = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [TAG_W-1:0]      tag;
    logic [OUT_TIME_W-1:0] at;
    logic                  last_flag;
  } timer_result_t;

  // one stimulus row; a pinned row carries its single result written out
  typedef struct packed {
    logic               op;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic [TAG_W-1:0]   tag;
    logic               pinned;
    logic [KIND_W-1:0]  kind;
    logic [31:0]        at;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // zero delay one-shot, fires on the first tick
    '{FUNC_SET,  31'd0,          31'd0,          8'h00, 1'b1, KIND_ACCEPT, 32'd0},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    // longest delay stays pending; longest period fires once, then stays pending
    '{FUNC_SET,  31'h7FFFFFFF,   31'd0,          8'hFF, 1'b1, KIND_ACCEPT, 32'd1},
    '{FUNC_SET,  31'd1,          31'h7FFFFFFF,   8'hA5, 1'b1, KIND_ACCEPT, 32'd1},
    // equal expiry, earlier insertion goes first; period one fires on every tick
    '{FUNC_SET,  31'd2,          31'd1,          8'h5A, 1'b1, KIND_ACCEPT, 32'd1},
    '{FUNC_SET,  31'd2,          31'd0,          8'h11, 1'b1, KIND_ACCEPT, 32'd1},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    // fill the table
    '{FUNC_SET,  31'd3,          31'd0,          8'h20, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h21, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h22, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h23, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h24, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h25, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h26, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h27, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h28, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h29, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h2A, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h2B, 1'b1, KIND_ACCEPT, 32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h2C, 1'b1, KIND_ACCEPT, 32'd4},
    // table full, refused with the request tag
    '{FUNC_SET,  31'd3,          31'd0,          8'h80, 1'b1, KIND_FULL,   32'd4},
    '{FUNC_SET,  31'd3,          31'd0,          8'h7E, 1'b1, KIND_FULL,   32'd4},
    // the period one timer fires on two ticks, then one tick fires fourteen timers
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0},
    '{FUNC_TICK, 31'd0,          31'd0,          8'h00, 1'b0, KIND_ACCEPT, 32'd0}
  };

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  req_valid   = 1'b0;
  logic                  req_stall;
  logic                  func        = FUNC_SET;
  logic [DELAY_W-1:0]    delay_ms    = '0;
  logic [DELAY_W-1:0]    period_ms   = '0;
  logic [TAG_W-1:0]      handler_tag = '0;
  logic                  rsp_valid;
  logic                  rsp_stall   = 1'b0;
  logic [KIND_W-1:0]     kind;
  logic [TAG_W-1:0]      fired_tag;
  logic [OUT_TIME_W-1:0] fire_time;
  logic                  last;

  // pinned expectation travels with the transaction it belongs to
  logic          pinned_valid  = 1'b0;
  timer_result_t pinned_result = '0;
  bit            steady        = 1'b0;

  // predictor copy of the timer table
  logic [TIME_BITS-1:0] clock_ms;
  int                   live_count;
  logic [TIME_BITS-1:0] due_at    [MAX_TIMERS];
  logic [DELAY_W-1:0]   reload_ms [MAX_TIMERS];
  logic [TAG_W-1:0]     owner_tag [MAX_TIMERS];
  timer_result_t        step_results [MAX_TIMERS];
  int                   step_count;

  timer_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  multi_timer_expiry_scheduler u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .delay_ms    (delay_ms),
    .period_ms   (period_ms),
    .handler_tag (handler_tag),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .kind        (kind),
    .fired_tag   (fired_tag),
    .fire_time   (fire_time),
    .last        (last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one set or tick against the predictor table, results into step_results
  task automatic advance_timers(input logic op, input logic [DELAY_W-1:0] dly,
                                input logic [DELAY_W-1:0] per, input logic [TAG_W-1:0] tg);
    logic [MAX_TIMERS-1:0] served;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS-1:0]  key;
    logic [TIME_BITS-1:0]  best_key;
    int                    pick;
    int                    j;
    bit                    scanning;
    step_count = 0;
    if (op == FUNC_SET) begin
      if (live_count < MAX_TIMERS) begin
        due_at[live_count]    = clock_ms + TIME_BITS'(dly);
        reload_ms[live_count] = per;
        owner_tag[live_count] = tg;
        live_count++;
        step_results[0] = '{KIND_ACCEPT, tg, clock_ms, 1'b1};
      end else begin
        step_results[0] = '{KIND_FULL, tg, clock_ms, 1'b1};
      end
      step_count = 1;
    end else begin
      clock_ms = clock_ms + 1'b1;
      served   = '0;
      best_key = '0;
      scanning = 1'b1;
      // each pass fires the earliest due timer not yet served this tick
      while (scanning) begin
        pick = -1;
        for (int i = 0; i < live_count; i++) begin
          gap = due_at[i] - clock_ms;
          if (!served[i] && (gap == '0 || gap[TIME_BITS-1])) begin
            key = gap ^ TIME_TOP;
            if (pick < 0 || key < best_key) begin
              pick     = i;
              best_key = key;
            end
          end
        end
        if (pick < 0) begin
          scanning = 1'b0;
        end else begin
          step_results[step_count] = '{KIND_FIRE, owner_tag[pick], clock_ms, 1'b0};
          step_count++;
          if (reload_ms[pick] != '0) begin
            due_at[pick] = due_at[pick] + TIME_BITS'(reload_ms[pick]);
            served[pick] = 1'b1;
          end else begin
            // one-shot leaves, the rest close up in order
            for (j = pick; j + 1 < live_count; j++) begin
              due_at[j]    = due_at[j+1];
              reload_ms[j] = reload_ms[j+1];
              owner_tag[j] = owner_tag[j+1];
              served[j]    = served[j+1];
            end
            live_count--;
          end
        end
      end
      if (step_count > 0) step_results[step_count-1].last_flag = 1'b1;
    end
  endtask

  // request side: random idle unless steady, then hold the transaction until accepted
  task automatic send_request(input logic op, input logic [DELAY_W-1:0] dly,
                              input logic [DELAY_W-1:0] per, input logic [TAG_W-1:0] tg,
                              input logic pin, input timer_result_t pin_res);
    while (!steady && $urandom_range(99) < 14) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    func          <= op;
    delay_ms      <= dly;
    period_ms     <= per;
    handler_tag   <= tg;
    pinned_valid  <= pin;
    pinned_result <= pin_res;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // result side stall
  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < 14);
  end

  // predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t want;
    if (!rst && req_valid && !req_stall) begin
      advance_timers(func, delay_ms, period_ms, handler_tag);
      if (pinned_valid) begin
        pending_results.push_back(pinned_result);
      end else begin
        for (int k = 0; k < step_count; k++) pending_results.push_back(step_results[k]);
      end
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      seen = '{kind, fired_tag, fire_time, last};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result kind=%0d tag=%02h time=%0d last=%0b",
                   kind, fired_tag, fire_time, last);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind=%0d tag=%02h time=%0d last=%0b, got kind=%0d tag=%02h time=%0d last=%0b",
                     want.kind, want.tag, want.at, want.last_flag,
                     seen.kind, seen.tag, seen.at, seen.last_flag);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    logic               op;
    logic [DELAY_W-1:0] dly;
    logic [DELAY_W-1:0] per;
    logic [TAG_W-1:0]   tg;
    int                 roll;
    clock_ms   = '0;
    live_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_request(DIRECTED[r].op, DIRECTED[r].delay, DIRECTED[r].period, DIRECTED[r].tag,
                   DIRECTED[r].pinned,
                   '{DIRECTED[r].kind, DIRECTED[r].tag, DIRECTED[r].at, 1'b1});
    end

    // random mix of ticks and sets, mostly short delays and one-shots
    for (int r = 0; r < N_RANDOM; r++) begin
      steady = (r >= 100 && r < 180);
      roll   = $urandom_range(99);
      tg     = TAG_W'($urandom);
      if (roll < 55) begin
        op  = FUNC_TICK;
        dly = DELAY_W'($urandom);
        per = DELAY_W'($urandom);
      end else begin
        op   = FUNC_SET;
        roll = $urandom_range(99);
        dly  = (roll < 3) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(40));
        roll = $urandom_range(99);
        if (roll < 1)      per = DELAY_W'($urandom);
        else if (roll < 6) per = DELAY_W'($urandom_range(25, 1));
        else               per = '0;
      end
      send_request(op, dly, per, tg, 1'b0, '0);
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
